### design/scac_pkg.sv
// Package for the step counter / activity classifier.
// Holds register map, reset values, result codes and shared structs.
// No dependencies.
package scac_pkg;

  localparam int unsigned NumRegs  = 7;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned SqW      = 28;
  localparam int unsigned M2W      = 32;
  localparam int unsigned NumBands = 4;
  localparam int unsigned TallyW   = 32;

  typedef enum logic [IdxW-1:0] {
    REG_PEAK    = 3'd0,
    REG_VALLEY  = 3'd1,
    REG_GRAVITY = 3'd2,
    REG_SLEEP   = 3'd3,
    REG_REST    = 3'd4,
    REG_WALK    = 3'd5,
    REG_RUN     = 3'd6
  } reg_idx_e;

  localparam logic [NumRegs-1:0][CfgW-1:0] CfgReset = {
    13'd576, 13'd256, 13'd64, 13'd19, 13'd1256, 13'd1280, 13'd1536
  };

  typedef enum logic [2:0] {
    ACT_SLEEPING = 3'd0,
    ACT_RESTING  = 3'd1,
    ACT_WALKING  = 3'd2,
    ACT_RUNNING  = 3'd3,
    ACT_PLAYING  = 3'd4
  } activity_e;

  // squared comparison bounds, derived from the config registers
  typedef struct packed {
    logic [SqW-1:0]                peak_sq;
    logic [SqW-1:0]                valley_sq;
    logic [NumBands-1:0][SqW-1:0]  hi_sq;
    logic [NumBands-1:0][SqW-1:0]  lo_sq;
    logic [NumBands-1:0]           lo_en;
  } bounds_t;

  typedef struct packed {
    logic      above_peak;
    logic      below_valley;
    activity_e cls;
  } eval_t;

endpackage

### design/scac_if.sv
// Stream interfaces for the step counter / activity classifier.
// Input channel carries one accelerometer sample, output one result.
// No dependencies.
interface scac_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface scac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_total;
  logic        step_seen;
  logic [2:0]  activity_class;

  modport source (output valid, output step_total, output step_seen,
                  output activity_class, input ready);
  modport sink   (input valid, input step_total, input step_seen,
                  input activity_class, output ready);
endinterface

### design/accel_step_counter_activity_classifier_unit.sv
// Top level of the step counter / activity classifier.
// Depends on scac_pkg, scac_if, scac_cfg, scac_eval.
//
// Takes one accelerometer sample per clock while the result side is not stalled
// and returns one result per sample (step total, step flag, activity class). A
// sample lands in an input register at its transfer; it is evaluated from there
// and written into the result register once that register is free, and the
// sustained rate is one sample per cycle without backpressure. The squared
// magnitude, the step hysteresis and the step tally all resolve in that single
// stage; a stalled result only holds the input side once the input register is
// full. Config writes reach the compares through the registered squared bounds.
module accel_step_counter_activity_classifier_unit
  import scac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  scac_in_if.sink          in_ch,
  scac_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bounds_t            bounds;
  eval_t              ev;
  logic               s1_valid_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic               out_valid_q;
  logic [TallyW-1:0]  total_q;
  logic               seen_q;
  activity_e          cls_q;
  logic               in_peak_q, in_peak_d;
  logic [TallyW-1:0]  tally_q, tally_d;
  logic               adv;
  logic               fire;
  logic               in_xfer;
  logic               hit;

  scac_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  scac_eval u_eval (
    .accel_x_i (x_q),
    .accel_y_i (y_q),
    .accel_z_i (z_q),
    .bounds_i  (bounds),
    .eval_o    (ev)
  );

  assign adv      = !out_valid_q || out_ch.ready;
  assign fire     = s1_valid_q && adv;
  assign in_ch.ready = !s1_valid_q || adv;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_comb begin
    hit       = !in_peak_q && ev.above_peak;
    in_peak_d = in_peak_q;
    tally_d   = tally_q;
    if (hit) begin
      in_peak_d = 1'b1;
      tally_d   = tally_q + TallyW'(1);
    end else if (in_peak_q && ev.below_valley) begin
      in_peak_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_peak_q   <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        in_peak_q <= in_peak_d;
        tally_q   <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= in_ch.accel_x;
      y_q <= in_ch.accel_y;
      z_q <= in_ch.accel_z;
    end
    if (fire) begin
      total_q <= tally_d;
      seen_q  <= hit;
      cls_q   <= ev.cls;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.step_total     = total_q;
  assign out_ch.step_seen      = seen_q;
  assign out_ch.activity_class = cls_q;

endmodule

### design/scac_cfg.sv
// APB-style config register file plus registered squared bounds.
// Depends on scac_pkg.
module scac_cfg
  import scac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output bounds_t          bounds_o
);

  logic [NumRegs-1:0][CfgW-1:0] regs_q;
  logic [IdxW-1:0]              idx;
  logic                         idx_ok;
  logic                         wr_en;
  bounds_t                      bounds_d;
  bounds_t                      bounds_q;
  logic [CfgW-1:0]              grav;
  logic [CfgW-1:0]              band   [NumBands];
  logic [CfgW:0]                sum_w  [NumBands];
  logic [CfgW-1:0]              dif_w  [NumBands];
  logic [2*CfgW-1:0]            dsq_w  [NumBands];

  assign idx    = paddr[AddrW-1:2];
  assign idx_ok = (32'(idx) < NumRegs);
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;
  assign prdata = idx_ok ? 32'(regs_q[idx]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CfgReset;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[CfgW-1:0];
    end
  end

  assign grav = regs_q[REG_GRAVITY];

  always_comb begin
    bounds_d.peak_sq   = SqW'(regs_q[REG_PEAK] * regs_q[REG_PEAK]);
    bounds_d.valley_sq = SqW'(regs_q[REG_VALLEY] * regs_q[REG_VALLEY]);
    for (int k = 0; k < NumBands; k++) begin
      band[k]              = regs_q[IdxW'(int'(REG_SLEEP) + k)];
      sum_w[k]             = {1'b0, grav} + {1'b0, band[k]};
      dif_w[k]             = grav - band[k];
      dsq_w[k]             = dif_w[k] * dif_w[k];
      bounds_d.hi_sq[k]    = SqW'(sum_w[k] * sum_w[k]);
      bounds_d.lo_sq[k]    = SqW'(dsq_w[k]);
      bounds_d.lo_en[k]    = (band[k] <= grav);
    end
  end

  always_ff @(posedge clk_i) begin
    bounds_q <= bounds_d;
  end

  assign bounds_o = bounds_q;

endmodule

### design/scac_eval.sv
// Squared magnitude and threshold/band compares for one sample.
// Depends on scac_pkg.
module scac_eval
  import scac_pkg::*;
(
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  bounds_t            bounds_i,
  output eval_t              eval_o
);

  logic signed [31:0]  xs;
  logic signed [31:0]  ys;
  logic signed [31:0]  zs;
  logic [M2W-1:0]      m2;
  logic [NumBands-1:0] band_ok;

  assign xs = accel_x_i * accel_x_i;
  assign ys = accel_y_i * accel_y_i;
  assign zs = accel_z_i * accel_z_i;
  assign m2 = M2W'(xs[30:0]) + M2W'(ys[30:0]) + M2W'(zs[30:0]);

  always_comb begin
    eval_o.above_peak   = (m2 > M2W'(bounds_i.peak_sq));
    eval_o.below_valley = (m2 < M2W'(bounds_i.valley_sq));
    for (int k = 0; k < NumBands; k++) begin
      band_ok[k] = (m2 < M2W'(bounds_i.hi_sq[k])) &&
                   (!bounds_i.lo_en[k] || (m2 > M2W'(bounds_i.lo_sq[k])));
    end
    // first band that holds wins
    eval_o.cls = ACT_PLAYING;
    for (int k = NumBands - 1; k >= 0; k--) begin
      if (band_ok[k]) begin
        eval_o.cls = activity_e'(3'(k));
      end
    end
  end

endmodule

### design/scac_checker.sv
// Port-level checks for the step counter / activity classifier.
// Depends on scac_pkg; bound to the top level below.
module scac_checker
  import scac_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] step_total,
  input logic        step_seen,
  input logic [2:0]  activity_class
);

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // results that leave on back-to-back edges are consecutive samples
  a_tally_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 out_xfer |->
      step_total == $past(step_total) + 32'(step_seen))
    else $error("step total does not follow step flag");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (activity_class <= 3'(ACT_PLAYING)))
    else $error("activity class out of range");

  // input side only stalls behind a held result
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(step_total) &&
      $stable(step_seen) && $stable(activity_class))
    else $error("stalled result changed");

endmodule

bind accel_step_counter_activity_classifier_unit scac_checker u_scac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .step_total     (out_ch.step_total),
  .step_seen      (out_ch.step_seen),
  .activity_class (out_ch.activity_class)
);

### bench/accel_step_counter_activity_classifier_unit_tb.sv
// Self-checking bench for the step counter / activity classifier: random and directed samples
// under random idling, results checked field by field against an in-bench predictor.
// Depends on scac_pkg, scac_in_if, scac_out_if and the accel_step_counter_activity_classifier_unit top.
module accel_step_counter_activity_classifier_unit_tb;
  import scac_pkg::*;

  localparam int LongHold   = 120;
  localparam int QuietLimit = 1000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } accel_sample_t;

  typedef struct {
    logic [TallyW-1:0] total;
    logic              seen;
    activity_e         cls;
  } step_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  scac_in_if  in_ch ();
  scac_out_if out_ch ();

  accel_step_counter_activity_classifier_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  accel_sample_t sample_q [$];
  step_result_t  result_q [$];
  step_result_t  want;
  accel_sample_t nxt;

  logic [CfgW-1:0]   cfg_shadow [NumRegs];
  logic              in_stride = 1'b0;
  logic [TallyW-1:0] exp_tally = '0;

  int   fail_cnt = 0;
  int   quiet_cycles = 0;
  int   src_gap = 0;
  int   hold_left = 0;
  int   stall_asked = 0;
  int   stall_served = 0;
  logic idle_on = 1'b1;
  logic in_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic band_holds(input longint m2, input longint b);
    longint g;
    g = longint'(cfg_shadow[REG_GRAVITY]);
    if (m2 >= (g + b) * (g + b)) return 1'b0;
    if (b > g) return 1'b1;
    return m2 > (g - b) * (g - b);
  endfunction

  function automatic activity_e classify(input longint m2);
    if (band_holds(m2, longint'(cfg_shadow[REG_SLEEP]))) return ACT_SLEEPING;
    if (band_holds(m2, longint'(cfg_shadow[REG_REST])))  return ACT_RESTING;
    if (band_holds(m2, longint'(cfg_shadow[REG_WALK])))  return ACT_WALKING;
    if (band_holds(m2, longint'(cfg_shadow[REG_RUN])))   return ACT_RUNNING;
    return ACT_PLAYING;
  endfunction

  function automatic void predict_step(input logic signed [15:0] ax,
                                       input logic signed [15:0] ay,
                                       input logic signed [15:0] az);
    longint       m2;
    longint       pk;
    longint       vl;
    step_result_t r;
    m2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    pk = longint'(cfg_shadow[REG_PEAK]);
    vl = longint'(cfg_shadow[REG_VALLEY]);
    r.seen = 1'b0;
    if (!in_stride && m2 > pk * pk) begin
      in_stride = 1'b1;
      exp_tally = exp_tally + 1;
      r.seen    = 1'b1;
    end else if (in_stride && m2 < vl * vl) begin
      in_stride = 1'b0;
    end
    r.total = exp_tally;
    r.cls   = classify(m2);
    result_q.push_back(r);
  endfunction

  // result check and prediction on input transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.step_total !== want.total) begin
            $error("step_total: expected %0d, got %0d", want.total, out_ch.step_total);
            fail_cnt++;
          end
          if (out_ch.step_seen !== want.seen) begin
            $error("step_seen: expected %0d, got %0d", want.seen, out_ch.step_seen);
            fail_cnt++;
          end
          if (out_ch.activity_class !== want.cls) begin
            $error("activity_class: expected %0d, got %0d", want.cls, out_ch.activity_class);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_step(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z);
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 17);
        in_ch.valid <= 1'b0;
      end else begin
        nxt = sample_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= nxt.x;
        in_ch.accel_y <= nxt.y;
        in_ch.accel_z <= nxt.z;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served++;
      hold_left = LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (sample_q.size() == 0 && !in_ch.valid && result_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("accel_step_counter_activity_classifier_unit verification failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(input int idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx < NumRegs) cfg_shadow[idx] = data[CfgW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk; a write past the last register must be dropped
  task automatic config_all(input int pk, input int vl, input int g, input int s,
                            input int r, input int w, input int u);
    int          vals [NumRegs];
    logic [31:0] data;
    vals = '{pk, vl, g, s, r, w, u};
    for (int i = 0; i < NumRegs; i++) begin
      data = $urandom();
      data[CfgW-1:0] = vals[i][CfgW-1:0];
      cfg_write(i, data);
    end
    cfg_write(NumRegs, $urandom());
  endtask

  task automatic random_config();
    int vals [NumRegs];
    vals[REG_PEAK]    = $urandom_range(900, 2600);
    vals[REG_VALLEY]  = $urandom_range(600, vals[REG_PEAK]);
    vals[REG_GRAVITY] = $urandom_range(600, 2000);
    vals[REG_SLEEP]   = $urandom_range(0, 60);
    vals[REG_REST]    = vals[REG_SLEEP] + $urandom_range(0, 100);
    vals[REG_WALK]    = vals[REG_REST] + $urandom_range(0, 400);
    vals[REG_RUN]     = vals[REG_WALK] + $urandom_range(0, 800);
    for (int i = 0; i < NumRegs; i++)
      if ($urandom_range(0, 5) == 0) vals[i] = $urandom_range(0, 8191);
    config_all(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5], vals[6]);
  endtask

  task automatic push_sample(input int x, input int y, input int z);
    accel_sample_t s;
    s.x = x[15:0];
    s.y = y[15:0];
    s.z = z[15:0];
    sample_q.push_back(s);
  endtask

  // one dominant axis near the wanted magnitude, small noise on the others
  task automatic push_shaped(input int mag);
    int v [3];
    int lead;
    if (mag < 0) mag = 0;
    if (mag > 32767) mag = 32767;
    lead = $urandom_range(0, 1) ? -mag : mag;
    for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 48)) - 24;
    v[$urandom_range(0, 2)] = lead;
    push_sample(v[0], v[1], v[2]);
  endtask

  task automatic load_random(input int n);
    int made;
    int hi_n;
    int lo_n;
    int base;
    int g;
    int b;
    made = 0;
    while (made < n) begin
      g = int'(cfg_shadow[REG_GRAVITY]);
      b = int'(cfg_shadow[int'(REG_SLEEP) + $urandom_range(0, 3)]);
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          hi_n = $urandom_range(1, 3);
          lo_n = $urandom_range(1, 3);
          for (int k = 0; k < hi_n; k++)
            push_shaped(int'(cfg_shadow[REG_PEAK]) + int'($urandom_range(1, 500)));
          for (int k = 0; k < lo_n; k++)
            push_shaped(int'(cfg_shadow[REG_VALLEY]) - int'($urandom_range(1, 500)));
          made += hi_n + lo_n;
        end
        [55:79]: begin
          case ($urandom_range(0, 3))
            0:       base = int'(cfg_shadow[REG_PEAK]);
            1:       base = int'(cfg_shadow[REG_VALLEY]);
            2:       base = g + b;
            default: base = g - b;
          endcase
          push_shaped(base + int'($urandom_range(0, 6)) - 3);
          made++;
        end
        [80:91]: begin
          push_sample($urandom(), $urandom(), $urandom());
          made++;
        end
        default: begin
          push_sample(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                      int'($urandom_range(0, 600)) - 300);
          made++;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_ch.valid || result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_directed();
    push_sample(0, 0, 0);
    push_sample(1256, 0, 0);
    push_sample(0, 0, -1237);
    push_sample(0, 1275, 0);
    push_sample(1274, 0, 0);
    push_sample(1320, 0, 0);
    push_sample(1512, 0, 0);
    push_sample(1536, 0, 0);
    push_sample(1537, 0, 0);
    push_sample(-32768, -32768, -32768);
    push_sample(1280, 0, 0);
    push_sample(0, 0, 1279);
    push_sample(32767, 32767, 32767);
    push_sample(-1279, 0, 0);
    push_sample(1832, 0, 0);
    push_sample(680, 0, 0);
    push_sample(681, 0, 0);
    push_sample(-1, -1, -1);
    push_sample(-32768, 0, 0);
    push_sample(0, -32768, 0);
    push_sample(1000, 700, -300);
    push_sample(21845, -21846, 0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.accel_x  = '0;
    in_ch.accel_y  = '0;
    in_ch.accel_z  = '0;
    out_ch.ready   = 1'b0;
    for (int i = 0; i < NumRegs; i++) cfg_shadow[i] = CfgReset[i];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_directed();
    load_random(200);
    wait_drained();

    // peak under valley, zero sleep band, walk and run bands reaching past gravity
    config_all(300, 900, 300, 0, 100, 400, 8191);
    push_sample(0, 0, 0);
    push_sample(300, 0, 0);
    push_sample(0, 650, 0);
    push_sample(0, 0, -1000);
    push_sample(0, 899, 0);
    load_random(150);
    wait_drained();

    config_all(0, 0, 0, 0, 0, 0, 0);
    load_random(100);
    wait_drained();

    config_all(8191, 8191, 8191, 8191, 8191, 8191, 8191);
    load_random(100);
    wait_drained();

    for (int i = 0; i < 4; i++) begin
      random_config();
      idle_on = ($urandom_range(0, 3) != 0);
      load_random(90);
      if (i == 1) stall_asked++;
      wait_drained();
      load_random(90);
      wait_drained();
    end

    config_all(1536, 1280, 1256, 19, 64, 256, 576);
    idle_on = 1'b0;
    load_random(300);
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("accel_step_counter_activity_classifier_unit verification clean");
    end else begin
      $display("accel_step_counter_activity_classifier_unit verification failed");
    end
    $finish;
  end

endmodule
